### rtl/gbn_pkg.sv
// Shared constants and codes for the Go-Back-N sender window.
package gbn_pkg;

	localparam int WINDOW_MAX  = 16;
	localparam int MAX_PAYLOAD = 256;

	localparam logic [4:0]  WINDOW_RESET  = 5'd10;
	localparam logic [15:0] TIMEOUT_RESET = 16'd15;

	localparam logic [1:0] REQ_SEND = 2'd0;
	localparam logic [1:0] REQ_ACK  = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	localparam logic [2:0] EV_SENT    = 3'd0;
	localparam logic [2:0] EV_RETX    = 3'd1;
	localparam logic [2:0] EV_REFUSED = 3'd2;
	localparam logic [2:0] EV_ACK     = 3'd3;
	localparam logic [2:0] EV_DROPPED = 3'd4;

	localparam logic CFG_WINDOW  = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	typedef logic [8:0]  len_t;
	typedef logic [31:0] seq_t;
	typedef logic [3:0]  slot_t;

endpackage

### rtl/go_back_n_sender_window.sv
// Go-Back-N sender window: sequence numbering, slot lengths, ack tracking and timed resend.
// Each transaction runs through a small sequencer that shares one restoring remainder unit:
// the slot of a sequence number (seq mod window) is found one dividend bit per cycle.
// A send request divides, writes its slot length and puts its result; an acknowledgement or
// a refused send puts its result directly; a tick that resends nothing returns to idle with no
// result; and a resend burst divides once, then reads and puts each packet resent (up to the
// window, at most 16); a stalled output adds its stall to any transaction that has a result. The block
// is not ready while a transaction is in work; a finished result waits in the output register
// and the next transaction is still taken. Slot lengths sit in a 16-entry memory with
// registered read; a window register of 0 acts as 1 and values above 16 act as 16.
module go_back_n_sender_window (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            req_type,
	input  gbn_pkg::len_t         payload_length,
	input  gbn_pkg::seq_t         ack_num,
	input  logic                  ack_good,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            event_kind,
	output gbn_pkg::seq_t         seq_num,
	output gbn_pkg::slot_t        slot,
	output gbn_pkg::len_t         length_out,
	output logic                  last,
	output logic                  all_done
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_SEND,
		S_RD,
		S_PUT
	} state_t;

	state_t state_q;

	logic [4:0]     win_q;
	logic [15:0]    timeout_q;
	gbn_pkg::seq_t  base_q;
	gbn_pkg::seq_t  next_q;
	logic           running_q;
	logic [15:0]    elapsed_q;
	logic           end_sent_q;

	logic [1:0]     op_q;
	gbn_pkg::len_t  len_q;
	gbn_pkg::seq_t  ack_q;
	logic           good_q;

	logic [4:0]     w_q;
	gbn_pkg::seq_t  div_q;
	logic [4:0]     bit_q;
	gbn_pkg::slot_t slot_q;
	gbn_pkg::seq_t  rs_seq_q;
	logic [4:0]     cnt_q;
	logic           resend_q;
	gbn_pkg::len_t  rd_q;

	logic [2:0]     st_kind_q;
	gbn_pkg::seq_t  st_seq_q;
	gbn_pkg::slot_t st_slot_q;
	gbn_pkg::len_t  st_len_q;
	logic           st_done_q;

	logic           out_valid_q;
	logic [2:0]     kind_q;
	gbn_pkg::seq_t  seq_out_q;
	gbn_pkg::slot_t slot_out_q;
	gbn_pkg::len_t  len_out_q;
	logic           last_q;
	logic           done_q;

	gbn_pkg::len_t  slot_lengths [gbn_pkg::WINDOW_MAX];

	logic [4:0]     w_eff;
	gbn_pkg::seq_t  flight;
	gbn_pkg::seq_t  ack_next;
	logic [15:0]    elapsed_sat;
	logic [4:0]     rem_t;
	logic [4:0]     rem_sub;
	gbn_pkg::len_t  len_sat;
	gbn_pkg::seq_t  next_inc;
	logic [4:0]     slot_inc;
	logic           can_load;
	logic           put_fire;
	logic           tick_fire;
	logic           resend_go;

	always_comb begin
		if (win_q == 5'd0) begin
			w_eff = 5'd1;
		end else if (win_q > 5'(gbn_pkg::WINDOW_MAX)) begin
			w_eff = 5'(gbn_pkg::WINDOW_MAX);
		end else begin
			w_eff = win_q;
		end
	end

	assign flight      = next_q - base_q;
	assign ack_next    = ack_q + 32'd1;
	assign elapsed_sat = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
	assign rem_t       = {slot_q, div_q[31]};
	assign rem_sub     = rem_t - w_q;
	assign len_sat     = (len_q > 9'(gbn_pkg::MAX_PAYLOAD)) ? 9'(gbn_pkg::MAX_PAYLOAD) : len_q;
	assign next_inc    = next_q + 32'd1;
	assign slot_inc    = {1'b0, slot_q} + 5'd1;
	assign can_load    = !out_valid_q || out_ready;
	assign put_fire    = (state_q == S_PUT) && can_load;
	assign tick_fire   = running_q && (elapsed_sat >= timeout_q);
	assign resend_go   = tick_fire && (flight != 32'd0);

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign event_kind = kind_q;
	assign seq_num    = seq_out_q;
	assign slot       = slot_out_q;
	assign length_out = len_out_q;
	assign last       = last_q;
	assign all_done   = done_q;

	// slot length store: written on send, read registered during resend
	always_ff @(posedge clk) begin
		if (state_q == S_SEND) begin
			slot_lengths[slot_q] <= len_sat;
		end
		if (state_q == S_RD) begin
			rd_q <= slot_lengths[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			win_q       <= gbn_pkg::WINDOW_RESET;
			timeout_q   <= gbn_pkg::TIMEOUT_RESET;
			base_q      <= 32'd1;
			next_q      <= 32'd1;
			running_q   <= 1'b0;
			elapsed_q   <= 16'd0;
			end_sent_q  <= 1'b0;
			out_valid_q <= 1'b0;
			resend_q    <= 1'b0;
			cnt_q       <= 5'd0;
			bit_q       <= 5'd0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == gbn_pkg::CFG_WINDOW) begin
					win_q <= cfg_data[4:0];
				end else begin
					timeout_q <= cfg_data;
				end
			end

			// hold a waiting result until it is taken
			out_valid_q <= put_fire || (out_valid_q && !out_ready);

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= req_type;
						len_q   <= payload_length;
						ack_q   <= ack_num;
						good_q  <= ack_good;
						state_q <= S_EXEC;
					end
				end

				S_EXEC: begin
					w_q       <= w_eff;
					resend_q  <= (op_q == gbn_pkg::REQ_TICK) && resend_go;
					st_slot_q <= '0;
					st_len_q  <= '0;
					case (op_q)
						gbn_pkg::REQ_SEND: begin
							st_seq_q  <= '0;
							st_done_q <= end_sent_q && (base_q == next_q);
							if (flight < {27'd0, w_eff} && !end_sent_q) begin
								div_q   <= next_q;
								slot_q  <= '0;
								bit_q   <= 5'd31;
								state_q <= S_DIV;
							end else begin
								st_kind_q <= gbn_pkg::EV_REFUSED;
								state_q   <= S_PUT;
							end
						end
						gbn_pkg::REQ_ACK: begin
							if (good_q) begin
								base_q    <= ack_next;
								running_q <= (ack_next != next_q);
								elapsed_q <= 16'd0;
								st_kind_q <= gbn_pkg::EV_ACK;
								st_seq_q  <= ack_q;
								st_done_q <= end_sent_q && (ack_next == next_q);
							end else begin
								st_kind_q <= gbn_pkg::EV_DROPPED;
								st_seq_q  <= '0;
								st_done_q <= end_sent_q && (base_q == next_q);
							end
							state_q <= S_PUT;
						end
						gbn_pkg::REQ_TICK: begin
							if (tick_fire) begin
								elapsed_q <= 16'd0;
							end else if (running_q) begin
								elapsed_q <= elapsed_sat;
							end
							// resend at most one window, starting at the base
							if (resend_go) begin
								cnt_q    <= (flight > {27'd0, w_eff}) ? w_eff : flight[4:0];
								rs_seq_q <= base_q;
								div_q    <= base_q;
								slot_q   <= '0;
								bit_q    <= 5'd31;
								state_q  <= S_DIV;
							end else begin
								state_q <= S_IDLE;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end

				S_DIV: begin
					// restoring remainder: one dividend bit per cycle
					slot_q <= (rem_t >= w_q) ? rem_sub[3:0] : rem_t[3:0];
					div_q  <= {div_q[30:0], 1'b0};
					bit_q  <= bit_q - 5'd1;
					if (bit_q == 5'd0) begin
						state_q <= resend_q ? S_RD : S_SEND;
					end
				end

				S_SEND: begin
					st_kind_q <= gbn_pkg::EV_SENT;
					st_seq_q  <= next_q;
					st_slot_q <= slot_q;
					st_len_q  <= len_sat;
					st_done_q <= (end_sent_q || (len_sat == 9'd0)) && (base_q == next_inc);
					if (base_q == next_q) begin
						running_q <= 1'b1;
						elapsed_q <= 16'd0;
					end
					if (len_sat == 9'd0) begin
						end_sent_q <= 1'b1;
					end
					next_q  <= next_inc;
					state_q <= S_PUT;
				end

				S_RD: begin
					state_q <= S_PUT;
				end

				S_PUT: begin
					if (can_load) begin
						if (resend_q) begin
							kind_q     <= gbn_pkg::EV_RETX;
							seq_out_q  <= rs_seq_q;
							slot_out_q <= slot_q;
							len_out_q  <= rd_q;
							last_q     <= (cnt_q == 5'd1);
							done_q     <= end_sent_q && (base_q == next_q);
							// advance to the next outstanding packet
							rs_seq_q   <= rs_seq_q + 32'd1;
							slot_q     <= (slot_inc == w_q) ? '0 : slot_inc[3:0];
							cnt_q      <= cnt_q - 5'd1;
							state_q    <= (cnt_q == 5'd1) ? S_IDLE : S_RD;
						end else begin
							kind_q     <= st_kind_q;
							seq_out_q  <= st_seq_q;
							slot_out_q <= st_slot_q;
							len_out_q  <= st_len_q;
							last_q     <= 1'b1;
							done_q     <= st_done_q;
							state_q    <= S_IDLE;
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_div_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> (w_q >= 5'd1 && w_q <= 5'(gbn_pkg::WINDOW_MAX)))
		else $error("remainder unit running with window out of range");

	a_slot_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> ({1'b0, slot_q} < w_q))
		else $error("resend slot outside the window");

	a_resend_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || (state_q == S_PUT && resend_q)) |-> cnt_q != 5'd0)
		else $error("resend burst with no packets left");

	a_send_advance: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEND |=> next_q == $past(next_q) + 32'd1)
		else $error("send did not advance the next sequence number");

endmodule

### test/tb_top.sv
// Self-checking testbench for the Go-Back-N sender window: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_top;

	localparam logic [1:0] REQ_UNUSED     = 2'd3;
	localparam int         DIRECTED_ROWS  = 22;
	localparam int         SETTLE_CYCLES  = 150;
	localparam int         WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		logic [2:0]     kind;
		gbn_pkg::seq_t  seq;
		gbn_pkg::slot_t slot;
		gbn_pkg::len_t  len;
		logic           last;
		logic           done;
	} window_event_t;

	typedef struct packed {
		logic [1:0]    op;
		gbn_pkg::len_t len;
		gbn_pkg::seq_t ack;
		logic          good;
		logic          typed;
		window_event_t ev;
	} stim_row_t;

	localparam window_event_t NO_EVENT = '0;

	logic           clk            = 1'b0;
	logic           arst_n         = 1'b0;
	logic           cfg_we         = 1'b0;
	logic           cfg_index      = gbn_pkg::CFG_WINDOW;
	logic [15:0]    cfg_data       = '0;
	logic           in_valid       = 1'b0;
	logic           in_ready;
	logic [1:0]     req_type       = gbn_pkg::REQ_SEND;
	gbn_pkg::len_t  payload_length = '0;
	gbn_pkg::seq_t  ack_num        = '0;
	logic           ack_good       = 1'b0;
	logic           out_valid;
	logic           out_ready      = 1'b0;
	logic [2:0]     event_kind;
	gbn_pkg::seq_t  seq_num;
	gbn_pkg::slot_t slot;
	gbn_pkg::len_t  length_out;
	logic           last;
	logic           all_done;

	go_back_n_sender_window i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.payload_length (payload_length),
		.ack_num        (ack_num),
		.ack_good       (ack_good),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_kind     (event_kind),
		.seq_num        (seq_num),
		.slot           (slot),
		.length_out     (length_out),
		.last           (last),
		.all_done       (all_done)
	);

	// Window state as the block should hold it
	logic [4:0]     cfg_window   = gbn_pkg::WINDOW_RESET;
	logic [15:0]    cfg_timeout  = gbn_pkg::TIMEOUT_RESET;
	gbn_pkg::seq_t  win_base     = 32'd1;
	gbn_pkg::seq_t  win_next     = 32'd1;
	gbn_pkg::len_t  win_lengths [gbn_pkg::WINDOW_MAX];
	logic           win_timer_on = 1'b0;
	logic [15:0]    win_elapsed  = '0;
	logic           win_end_sent = 1'b0;

	window_event_t step_results[$];
	window_event_t pending_events[$];
	window_event_t want;
	window_event_t observed;

	int unsigned error_count     = 0;
	int unsigned results_checked = 0;
	int unsigned items_applied   = 0;
	int unsigned quiet_cycles    = 0;
	int unsigned burst_left      = 0;
	int unsigned ready_mode      = 0;
	int unsigned ready_left      = 0;
	logic [15:0] ready_pattern   = 16'hFFFF;

	// Rows with a typed result check reset state, extremes and refusals directly
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{gbn_pkg::REQ_ACK,  9'd0,   32'hFFFF_FFFF, 1'b0, 1'b1,
			'{gbn_pkg::EV_DROPPED, 32'd0, 4'd0, 9'd0, 1'b1, 1'b0}},
		'{REQ_UNUSED,        9'h1FF, 32'd0,         1'b1, 1'b0, NO_EVENT},
		'{gbn_pkg::REQ_TICK, 9'd0,   32'd0,         1'b0, 1'b0, NO_EVENT},
		'{gbn_pkg::REQ_SEND, 9'd1,   32'd0,         1'b0, 1'b1,
			'{gbn_pkg::EV_SENT, 32'd1, 4'd1, 9'd1, 1'b1, 1'b0}},
		'{gbn_pkg::REQ_SEND, 9'd256, 32'd0,         1'b0, 1'b1,
			'{gbn_pkg::EV_SENT, 32'd2, 4'd2, 9'd256, 1'b1, 1'b0}},
		'{gbn_pkg::REQ_SEND, 9'd511, 32'hFFFF_FFFF, 1'b1, 1'b1,
			'{gbn_pkg::EV_SENT, 32'd3, 4'd3, 9'd256, 1'b1, 1'b0}},
		'{gbn_pkg::REQ_SEND, 9'd300, 32'd0,         1'b0, 1'b0, NO_EVENT},
		'{gbn_pkg::REQ_SEND, 9'd255, 32'd0,         1'b0, 1'b0, NO_EVENT},
		'{gbn_pkg::REQ_SEND, 9'd128, 32'd0,         1'b0, 1'b0, NO_EVENT},
		'{gbn_pkg::REQ_SEND, 9'd170, 32'd0,         1'b0, 1'b0, NO_EVENT},
		'{gbn_pkg::REQ_SEND, 9'd85,  32'd0,         1'b0, 1'b0, NO_EVENT},
		'{gbn_pkg::REQ_SEND, 9'd7,   32'd0,         1'b0, 1'b0, NO_EVENT},
		'{gbn_pkg::REQ_SEND, 9'd100, 32'd0,         1'b0, 1'b0, NO_EVENT},
		'{gbn_pkg::REQ_SEND, 9'd42,  32'd0,         1'b0, 1'b1,
			'{gbn_pkg::EV_REFUSED, 32'd0, 4'd0, 9'd0, 1'b1, 1'b0}},
		'{gbn_pkg::REQ_TICK, 9'd0,   32'd0,         1'b0, 1'b0, NO_EVENT},
		'{gbn_pkg::REQ_ACK,  9'd0,   32'd5,         1'b1, 1'b1,
			'{gbn_pkg::EV_ACK, 32'd5, 4'd0, 9'd0, 1'b1, 1'b0}},
		'{gbn_pkg::REQ_TICK, 9'd0,   32'd0,         1'b0, 1'b0, NO_EVENT},
		'{gbn_pkg::REQ_ACK,  9'd0,   32'd10,        1'b1, 1'b1,
			'{gbn_pkg::EV_ACK, 32'd10, 4'd0, 9'd0, 1'b1, 1'b0}},
		'{gbn_pkg::REQ_TICK, 9'd0,   32'd0,         1'b0, 1'b0, NO_EVENT},
		'{gbn_pkg::REQ_ACK,  9'd0,   32'hFFFF_FFFF, 1'b1, 1'b1,
			'{gbn_pkg::EV_ACK, 32'hFFFF_FFFF, 4'd0, 9'd0, 1'b1, 1'b0}},
		'{gbn_pkg::REQ_TICK, 9'd0,   32'd0,         1'b0, 1'b0, NO_EVENT},
		'{gbn_pkg::REQ_ACK,  9'd0,   32'd10,        1'b1, 1'b1,
			'{gbn_pkg::EV_ACK, 32'd10, 4'd0, 9'd0, 1'b1, 1'b0}}
	};

	initial forever #5 clk = ~clk;

	function automatic gbn_pkg::seq_t current_window();
		if (cfg_window == 5'd0)
			return 32'd1;
		if (cfg_window > gbn_pkg::WINDOW_MAX)
			return gbn_pkg::seq_t'(gbn_pkg::WINDOW_MAX);
		return gbn_pkg::seq_t'(cfg_window);
	endfunction

	function automatic void add_event(logic [2:0] kind, gbn_pkg::seq_t seq, gbn_pkg::slot_t s,
	                                  gbn_pkg::len_t len);
		window_event_t ev;
		ev.kind = kind;
		ev.seq  = seq;
		ev.slot = s;
		ev.len  = len;
		ev.last = 1'b0;
		ev.done = win_end_sent && (win_base == win_next);
		step_results.push_back(ev);
	endfunction

	function automatic void predict_window_events(logic [1:0] op, gbn_pkg::len_t len_in,
	                                              gbn_pkg::seq_t ack_in, logic good_in);
		gbn_pkg::seq_t  win;
		gbn_pkg::seq_t  flight;
		gbn_pkg::seq_t  seq;
		gbn_pkg::slot_t s;
		gbn_pkg::len_t  len_sat;
		window_event_t  tail;
		win = current_window();
		step_results.delete();
		case (op)
			gbn_pkg::REQ_SEND: begin
				flight = win_next - win_base;
				if (flight < win && !win_end_sent) begin
					s = gbn_pkg::slot_t'(win_next % win);
					len_sat = (len_in > gbn_pkg::len_t'(gbn_pkg::MAX_PAYLOAD)) ?
						gbn_pkg::len_t'(gbn_pkg::MAX_PAYLOAD) : len_in;
					win_lengths[s] = len_sat;
					if (win_base == win_next) begin
						win_timer_on = 1'b1;
						win_elapsed  = '0;
					end
					seq = win_next;
					win_next = win_next + 32'd1;
					if (len_sat == '0)
						win_end_sent = 1'b1;
					add_event(gbn_pkg::EV_SENT, seq, s, len_sat);
				end else begin
					add_event(gbn_pkg::EV_REFUSED, '0, '0, '0);
				end
			end
			gbn_pkg::REQ_ACK: begin
				if (good_in) begin
					win_base     = ack_in + 32'd1;
					win_timer_on = (win_base != win_next);
					win_elapsed  = '0;
					add_event(gbn_pkg::EV_ACK, ack_in, '0, '0);
				end else begin
					add_event(gbn_pkg::EV_DROPPED, '0, '0, '0);
				end
			end
			gbn_pkg::REQ_TICK: begin
				if (win_timer_on) begin
					if (win_elapsed != 16'hFFFF)
						win_elapsed = win_elapsed + 16'd1;
					if (win_elapsed >= cfg_timeout) begin
						win_elapsed = '0;
						flight = win_next - win_base;
						// resend at most one window, even after an ack past next_seq
						if (flight > win)
							flight = win;
						for (int i = 0; i < int'(flight); i++) begin
							seq = win_base + gbn_pkg::seq_t'(i);
							s = gbn_pkg::slot_t'(seq % win);
							add_event(gbn_pkg::EV_RETX, seq, s, win_lengths[s]);
						end
					end
				end
			end
			default: ;
		endcase
		if (step_results.size() != 0) begin
			tail = step_results.pop_back();
			tail.last = 1'b1;
			step_results.push_back(tail);
		end
	endfunction

	task automatic report_error(string what, window_event_t exp_ev, window_event_t got_ev);
		error_count++;
		if (error_count <= 10) begin
			$display("%0t %s: expected kind %0d seq %h slot %0d len %0d last %b done %b,",
				$time, what, exp_ev.kind, exp_ev.seq, exp_ev.slot, exp_ev.len, exp_ev.last,
				exp_ev.done);
			$display("    got kind %0d seq %h slot %0d len %0d last %b done %b",
				got_ev.kind, got_ev.seq, got_ev.slot, got_ev.len, got_ev.last, got_ev.done);
		end
	endtask

	task automatic write_register(logic idx, logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == gbn_pkg::CFG_WINDOW)
			cfg_window = data[4:0];
		else
			cfg_timeout = data;
		@(posedge clk);
	endtask

	task automatic apply_request(logic [1:0] op, gbn_pkg::len_t len_in, gbn_pkg::seq_t ack_in,
	                             logic good_in, logic typed, window_event_t typed_ev);
		in_valid       <= 1'b1;
		req_type       <= op;
		payload_length <= len_in;
		ack_num        <= ack_in;
		ack_good       <= good_in;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_window_events(op, len_in, ack_in, good_in);
		if (typed)
			pending_events.push_back(typed_ev);
		else
			foreach (step_results[k])
				pending_events.push_back(step_results[k]);
		if (op != REQ_UNUSED)
			items_applied++;
	endtask

	// Bursts of back-to-back transactions separated by idle gaps
	task automatic pace_sender();
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ?
				$urandom_range(20, 40) : $urandom_range(0, 8);
		end
	endtask

	// Hold off the sender until every expected result is out and the block is quiet
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic start_phase(logic [15:0] window, logic [15:0] timeout);
		drain_results();
		write_register(gbn_pkg::CFG_WINDOW, window);
		write_register(gbn_pkg::CFG_TIMEOUT, timeout);
	endtask

	task automatic run_random_phase(int unsigned count);
		int unsigned   done_items;
		int unsigned   pick;
		gbn_pkg::seq_t flight;
		gbn_pkg::len_t len;
		done_items = 0;
		while (done_items < count) begin
			flight = win_next - win_base;
			if (flight > current_window())
				flight = current_window();
			pick = $urandom_range(0, 99);
			len  = gbn_pkg::len_t'($urandom_range(0, 511));
			if (pick < 45) begin
				len = ($urandom_range(0, 4) == 0) ? gbn_pkg::len_t'($urandom_range(257, 511)) :
					gbn_pkg::len_t'($urandom_range(1, 256));
				apply_request(gbn_pkg::REQ_SEND, len, $urandom, 1'($urandom_range(0, 1)),
					1'b0, NO_EVENT);
			end else if (pick < 72) begin
				// in-window ack; also pulls the base back after a stray one
				apply_request(gbn_pkg::REQ_ACK, len,
					win_next - 32'd1 - $urandom_range(0, flight), 1'b1, 1'b0, NO_EVENT);
			end else if (pick < 77) begin
				apply_request(gbn_pkg::REQ_ACK, len, $urandom, 1'b0, 1'b0, NO_EVENT);
			end else if (pick < 95) begin
				apply_request(gbn_pkg::REQ_TICK, len, $urandom, 1'($urandom_range(0, 1)),
					1'b0, NO_EVENT);
			end else if (pick < 98) begin
				apply_request(gbn_pkg::REQ_ACK, len, $urandom, 1'b1, 1'b0, NO_EVENT);
			end else begin
				apply_request(REQ_UNUSED, len, $urandom, 1'($urandom_range(0, 1)),
					1'b0, NO_EVENT);
			end
			if (pick < 98)
				done_items++;
			if ($urandom_range(0, 99) == 0)
				drain_results();
			else
				pace_sender();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// timeout 0 expires on the first tick; window stays at its reset value
		write_register(gbn_pkg::CFG_TIMEOUT, 16'd0);
		foreach (directed_rows[r]) begin
			apply_request(directed_rows[r].op, directed_rows[r].len, directed_rows[r].ack,
				directed_rows[r].good, directed_rows[r].typed, directed_rows[r].ev);
			pace_sender();
		end

		// Write every slot once so later resends never read an empty one
		start_phase(16'd16, 16'd3);
		repeat (gbn_pkg::WINDOW_MAX) begin
			apply_request(gbn_pkg::REQ_SEND, gbn_pkg::len_t'($urandom_range(1, 256)), '0,
				1'b0, 1'b0, NO_EVENT);
			pace_sender();
		end
		apply_request(gbn_pkg::REQ_ACK, '0, win_next - 32'd1, 1'b1, 1'b0, NO_EVENT);
		run_random_phase(45);

		start_phase(16'd1, 16'd1);
		run_random_phase(45);
		start_phase(16'd0, 16'd2);
		run_random_phase(45);
		start_phase(16'd31, 16'd4);
		run_random_phase(45);
		start_phase(16'd7, 16'hFFFF);
		run_random_phase(40);
		start_phase(16'd4, 16'd2);
		run_random_phase(45);
		start_phase(16'd16, 16'd1);
		run_random_phase(45);

		// End of file: resend includes the empty packet, then all_done once acked
		start_phase(16'd8, 16'd2);
		apply_request(gbn_pkg::REQ_ACK, '0, win_next - 32'd1, 1'b1, 1'b0, NO_EVENT);
		repeat (3) begin
			apply_request(gbn_pkg::REQ_SEND, gbn_pkg::len_t'($urandom_range(1, 256)), '0,
				1'b0, 1'b0, NO_EVENT);
			pace_sender();
		end
		apply_request(gbn_pkg::REQ_ACK, '0, win_base, 1'b1, 1'b0, NO_EVENT);
		apply_request(gbn_pkg::REQ_SEND, 9'd0, '0, 1'b0, 1'b0, NO_EVENT);
		apply_request(gbn_pkg::REQ_TICK, '0, '0, 1'b0, 1'b0, NO_EVENT);
		apply_request(gbn_pkg::REQ_TICK, '0, '0, 1'b0, 1'b0, NO_EVENT);
		apply_request(gbn_pkg::REQ_SEND, 9'd9, '0, 1'b0, 1'b0, NO_EVENT);
		apply_request(gbn_pkg::REQ_ACK, '0, win_next - 32'd1, 1'b1, 1'b0, NO_EVENT);
		apply_request(gbn_pkg::REQ_SEND, 9'd9, '0, 1'b0, 1'b0, NO_EVENT);
		apply_request(gbn_pkg::REQ_ACK, '0, 32'd0, 1'b0, 1'b0, NO_EVENT);
		apply_request(gbn_pkg::REQ_TICK, '0, '0, 1'b0, 1'b0, NO_EVENT);

		drain_results();
		error_count += pending_events.size();
		$display("Applied %0d requests, checked %0d results over windows 0 to 31,",
			items_applied, results_checked);
		$display("timeouts 0 to 65535, sequence wrap, stray acks and end of file; %0d errors.",
			error_count);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver: switch between always ready, a rotating pattern and heavy stalls
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode    = $urandom_range(0, 3);
			ready_left    = $urandom_range(16, 96);
			ready_pattern = 16'($urandom);
		end else begin
			ready_left--;
		end
		ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
		case (ready_mode)
			0, 1: out_ready <= 1'b1;
			2: out_ready <= ready_pattern[0];
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			observed = {event_kind, seq_num, slot, length_out, last, all_done};
			if (pending_events.size() == 0) begin
				report_error("result with nothing expected", NO_EVENT, observed);
			end else begin
				want = pending_events.pop_front();
				results_checked++;
				if (observed !== want)
					report_error("result mismatch", want, observed);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
